[rtl/dabd_pkg.sv]
// shared widths, types, register codes and reset values of the detection decode block
package dabd_pkg;

  localparam int SCORE_BITS    = 16;
  localparam int BOX_BITS      = 18;
  localparam int DIM_BITS      = 13;
  localparam int ID_BITS       = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef logic [SCORE_BITS-1:0]        score_t;
  typedef logic signed [BOX_BITS-1:0]   box_t;
  typedef logic [DIM_BITS-1:0]          dim_t;
  typedef logic signed [ID_BITS-1:0]    id_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0]     cfg_data_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCORE_THRESHOLD = 2'd0,
    REG_BOX_NORMALIZED  = 2'd1,
    REG_IMAGE_WIDTH     = 2'd2,
    REG_IMAGE_HEIGHT    = 2'd3
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam score_t RST_SCORE_THRESHOLD = score_t'(45875);  // 0.7 of full scale
  localparam logic   RST_BOX_NORMALIZED  = 1'b1;
  localparam dim_t   RST_IMAGE_WIDTH     = dim_t'(1920);
  localparam dim_t   RST_IMAGE_HEIGHT    = dim_t'(1080);

  // smallest image side that still gives a result
  localparam dim_t   MIN_IMAGE_DIM       = dim_t'(2);

endpackage

[rtl/dabd_if.sv]
// valid/ready channel interfaces: detection slots in, decoded boxes out, register writes

interface dabd_slot_if import dabd_pkg::*; ();
  logic   valid;
  logic   ready;
  score_t score;
  box_t   box_left;
  box_t   box_top;
  box_t   box_right;
  box_t   box_bottom;
  dim_t   region_x;
  dim_t   region_y;
  dim_t   region_w;
  dim_t   region_h;
  id_t    region_id;
  logic   last;

  modport source (
    output valid, score, box_left, box_top, box_right, box_bottom,
           region_x, region_y, region_w, region_h, region_id, last,
    input  ready
  );
  modport sink (
    input  valid, score, box_left, box_top, box_right, box_bottom,
           region_x, region_y, region_w, region_h, region_id, last,
    output ready
  );
endinterface

interface dabd_res_if import dabd_pkg::*; ();
  logic   valid;
  logic   ready;
  id_t    out_id;
  dim_t   out_x;
  dim_t   out_y;
  dim_t   out_w;
  dim_t   out_h;
  score_t out_score;

  modport source (
    output valid, out_id, out_x, out_y, out_w, out_h, out_score,
    input  ready
  );
  modport sink (
    input  valid, out_id, out_x, out_y, out_w, out_h, out_score,
    output ready
  );
endinterface

interface dabd_cfg_if import dabd_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/detection_argmax_box_decode_unit.sv]
// detection argmax over a region's slots and box decode into image pixels
//
//   channel  dir  handshake              payload
//   cfg      in   cfg.valid/cfg.ready    index, data (register write)
//   slot     in   slot.valid/slot.ready  score, box edges, region, region_id, last
//   result   out  result.valid/ready     out_id, out_x, out_y, out_w, out_h, out_score
//
// one slot item is taken every cycle while stage 1 can move; the running maximum is a single
// compare at the input. a last item past the threshold and size checks runs through register
// stages (winning slot, crop fit, multiply, truncate, crop clamp with offset, image clamp).
// rst is synchronous: registers return to their reset values, the run and pipeline empty.
// a stall on result only backs up the stages that hold items; empty stages keep taking items.
// cfg is always ready and takes one write per cycle.
module detection_argmax_box_decode_unit import dabd_pkg::*; #(
  parameter int BOX_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst,
  dabd_cfg_if.sink  cfg,
  dabd_slot_if.sink slot,
  dabd_res_if.source result
);

  localparam int MUL_BITS  = BOX_BITS + DIM_BITS + 1;
  localparam int RAW_BITS  = BOX_BITS + BOX_FRAC_BITS;
  localparam int PRD_BITS  = (MUL_BITS > RAW_BITS) ? MUL_BITS : RAW_BITS;
  localparam int SCL_BITS  = PRD_BITS - BOX_FRAC_BITS;
  localparam int EDGE_BITS = DIM_BITS + 3;
  localparam logic [PRD_BITS-1:0] TRUNC_BIAS =
    PRD_BITS'((64'd1 << BOX_FRAC_BITS) - 64'd1);

  // configuration registers
  score_t score_threshold;
  logic   box_normalized;
  dim_t   image_width;
  dim_t   image_height;

  // running maximum of the current run
  logic   run_started;
  score_t best_score;
  box_t   best_box [4];

  // stage valid bits and advance conditions
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // stage 1: winning slot and region
  score_t s1_score;
  id_t    s1_id;
  box_t   s1_box [4];
  dim_t   s1_org [2];
  dim_t   s1_ext [2];

  // stage 2: crop corner and size
  score_t s2_score;
  id_t    s2_id;
  box_t   s2_box [4];
  dim_t   s2_org [2];
  dim_t   s2_size [2];

  // stage 3: products
  score_t s3_score;
  id_t    s3_id;
  dim_t   s3_org [2];
  dim_t   s3_size [2];
  logic signed [PRD_BITS-1:0] s3_prd [4];

  // stage 4: scaled box
  score_t s4_score;
  id_t    s4_id;
  dim_t   s4_org [2];
  dim_t   s4_size [2];
  logic signed [SCL_BITS-1:0] s4_scl [4];

  // stage 5: box in image coordinates before the final clamp
  score_t s5_score;
  id_t    s5_id;
  logic signed [EDGE_BITS-1:0] s5_lo [2];
  logic signed [EDGE_BITS-1:0] s5_hi [2];

  logic   slot_acc;
  logic   take;
  logic   emit;
  score_t cur_score;
  box_t   cur_box [4];
  box_t   in_box [4];
  dim_t   frame [2];

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= RST_SCORE_THRESHOLD;
      box_normalized  <= RST_BOX_NORMALIZED;
      image_width     <= RST_IMAGE_WIDTH;
      image_height    <= RST_IMAGE_HEIGHT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_SCORE_THRESHOLD: score_threshold <= cfg.data[SCORE_BITS-1:0];
        REG_BOX_NORMALIZED:  box_normalized  <= cfg.data[0];
        REG_IMAGE_WIDTH:     image_width     <= cfg.data[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg.data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign frame[0] = image_width;
  assign frame[1] = image_height;

  // backpressure: a stage takes a new item when empty or when it moves on
  assign rdy6 = !result.valid || result.ready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign slot.ready = rdy1;
  assign slot_acc = slot.valid && slot.ready;

  // argmax compare, first maximum of the run wins
  always_comb begin
    in_box[0] = slot.box_left;
    in_box[1] = slot.box_top;
    in_box[2] = slot.box_right;
    in_box[3] = slot.box_bottom;
    take = !run_started || (slot.score > best_score);
    cur_score = take ? slot.score : best_score;
    for (int k = 0; k < 4; k++) begin
      cur_box[k] = take ? in_box[k] : best_box[k];
    end
    emit = slot.last && (cur_score > score_threshold) &&
           (image_width >= MIN_IMAGE_DIM) && (image_height >= MIN_IMAGE_DIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_started <= 1'b0;
    end else if (slot_acc) begin
      run_started <= !slot.last;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_acc) begin
      best_score <= cur_score;
      best_box   <= cur_box;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= slot_acc && emit;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) result.valid <= v5;
    end
  end

  // stage 1 load: best slot including this item, region of the last item
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_score  <= cur_score;
      s1_id     <= slot.region_id;
      s1_box    <= cur_box;
      s1_org[0] <= slot.region_x;
      s1_org[1] <= slot.region_y;
      s1_ext[0] <= slot.region_w;
      s1_ext[1] <= slot.region_h;
    end
  end

  // crop fit: clamp the region into the image
  dim_t               c_lim [2];
  dim_t               c_lo [2];
  logic [DIM_BITS:0]  c_hi_raw [2];
  logic [DIM_BITS:0]  c_hi_min [2];
  logic [DIM_BITS:0]  c_hi1 [2];
  logic [DIM_BITS:0]  c_hi_lim [2];
  logic [DIM_BITS:0]  c_hi [2];
  dim_t               c_size [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      c_lim[a]    = frame[a] - MIN_IMAGE_DIM;
      c_lo[a]     = (s1_org[a] > c_lim[a]) ? c_lim[a] : s1_org[a];
      c_hi_raw[a] = {1'b0, s1_org[a]} + {1'b0, s1_ext[a]};
      c_hi_min[a] = {1'b0, c_lo[a]} + (DIM_BITS+1)'(1);
      c_hi1[a]    = (c_hi_raw[a] < c_hi_min[a]) ? c_hi_min[a] : c_hi_raw[a];
      c_hi_lim[a] = {1'b0, frame[a]} - (DIM_BITS+1)'(1);
      c_hi[a]     = (c_hi1[a] > c_hi_lim[a]) ? c_hi_lim[a] : c_hi1[a];
      c_size[a]   = DIM_BITS'(c_hi[a] - {1'b0, c_lo[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_score <= s1_score;
      s2_id    <= s1_id;
      s2_box   <= s1_box;
      s2_org   <= c_lo;
      s2_size  <= c_size;
    end
  end

  // scale by crop size, or place pixel values at the same fraction point
  logic signed [MUL_BITS-1:0] mul [4];
  logic signed [PRD_BITS-1:0] prd [4];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mul[a]   = MUL_BITS'(s2_box[a]) * MUL_BITS'($signed({1'b0, s2_size[a]}));
      mul[a+2] = MUL_BITS'(s2_box[a+2]) * MUL_BITS'($signed({1'b0, s2_size[a]}));
    end
    for (int k = 0; k < 4; k++) begin
      prd[k] = box_normalized ? PRD_BITS'(mul[k])
                              : (PRD_BITS'(s2_box[k]) <<< BOX_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_score <= s2_score;
      s3_id    <= s2_id;
      s3_org   <= s2_org;
      s3_size  <= s2_size;
      s3_prd   <= prd;
    end
  end

  // drop the fraction bits, truncating toward zero
  logic [PRD_BITS-1:0] biased [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      biased[k] = s3_prd[k] + (s3_prd[k][PRD_BITS-1] ? TRUNC_BIAS : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_score <= s3_score;
      s4_id    <= s3_id;
      s4_org   <= s3_org;
      s4_size  <= s3_size;
      for (int k = 0; k < 4; k++) begin
        s4_scl[k] <= $signed(biased[k][PRD_BITS-1:BOX_FRAC_BITS]);
      end
    end
  end

  // clamp the box into the crop and move it to the crop corner
  logic signed [SCL_BITS-1:0]  b_sz [2];
  logic signed [SCL_BITS-1:0]  b_lim_lo [2];
  logic signed [SCL_BITS-1:0]  b_lim_hi [2];
  logic signed [SCL_BITS-1:0]  b_lo1 [2];
  logic signed [SCL_BITS-1:0]  b_lo [2];
  logic signed [SCL_BITS-1:0]  b_hi_min [2];
  logic signed [SCL_BITS-1:0]  b_hi1 [2];
  logic signed [SCL_BITS-1:0]  b_hi [2];
  logic signed [EDGE_BITS-1:0] b_org [2];
  logic signed [EDGE_BITS-1:0] img_lo [2];
  logic signed [EDGE_BITS-1:0] img_hi [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      b_sz[a]     = SCL_BITS'($signed({1'b0, s4_size[a]}));
      b_lim_lo[a] = b_sz[a] - SCL_BITS'(2);
      b_lim_hi[a] = b_sz[a] - SCL_BITS'(1);
      b_lo1[a]    = s4_scl[a][SCL_BITS-1] ? '0 : s4_scl[a];
      b_lo[a]     = (b_lo1[a] > b_lim_lo[a]) ? b_lim_lo[a] : b_lo1[a];
      b_hi_min[a] = b_lo[a] + SCL_BITS'(1);
      b_hi1[a]    = (s4_scl[a+2] < b_hi_min[a]) ? b_hi_min[a] : s4_scl[a+2];
      b_hi[a]     = (b_hi1[a] > b_lim_hi[a]) ? b_lim_hi[a] : b_hi1[a];
      b_org[a]    = EDGE_BITS'($signed({1'b0, s4_org[a]}));
      img_lo[a]   = EDGE_BITS'(b_lo[a]) + b_org[a];
      img_hi[a]   = EDGE_BITS'(b_hi[a]) + b_org[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_score <= s4_score;
      s5_id    <= s4_id;
      s5_lo    <= img_lo;
      s5_hi    <= img_hi;
    end
  end

  // clamp into the image and form corner and size
  logic signed [EDGE_BITS-1:0] f_lim_lo [2];
  logic signed [EDGE_BITS-1:0] f_lim_hi [2];
  logic signed [EDGE_BITS-1:0] f_lo1 [2];
  logic signed [EDGE_BITS-1:0] f_lo [2];
  logic signed [EDGE_BITS-1:0] f_hi_min [2];
  logic signed [EDGE_BITS-1:0] f_hi1 [2];
  logic signed [EDGE_BITS-1:0] f_hi [2];
  logic signed [EDGE_BITS-1:0] f_ext [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      f_lim_lo[a] = EDGE_BITS'($signed({1'b0, frame[a]})) - EDGE_BITS'(2);
      f_lim_hi[a] = EDGE_BITS'($signed({1'b0, frame[a]})) - EDGE_BITS'(1);
      f_lo1[a]    = s5_lo[a][EDGE_BITS-1] ? '0 : s5_lo[a];
      f_lo[a]     = (f_lo1[a] > f_lim_lo[a]) ? f_lim_lo[a] : f_lo1[a];
      f_hi_min[a] = f_lo[a] + EDGE_BITS'(1);
      f_hi1[a]    = (s5_hi[a] < f_hi_min[a]) ? f_hi_min[a] : s5_hi[a];
      f_hi[a]     = (f_hi1[a] > f_lim_hi[a]) ? f_lim_hi[a] : f_hi1[a];
      f_ext[a]    = f_hi[a] - f_lo[a];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rdy6) begin
      result.out_id    <= s5_id;
      result.out_x     <= DIM_BITS'(f_lo[0]);
      result.out_y     <= DIM_BITS'(f_lo[1]);
      result.out_w     <= DIM_BITS'(f_ext[0]);
      result.out_h     <= DIM_BITS'(f_ext[1]);
      result.out_score <= s5_score;
    end
  end

`ifndef SYNTH
  // a decoded box always has a nonzero size
  a_out_size: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.out_w != '0) && (result.out_h != '0))
    else $error("result box with zero size");

  // a slot that is not last keeps the run open
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    slot_acc && !slot.last |=> run_started)
    else $error("run not open after a slot item");

  // the last slot closes the run
  a_run_close: assert property (@(posedge clk) disable iff (rst)
    slot_acc && slot.last |=> !run_started)
    else $error("run still open after the last item");

  // only scores above the threshold enter the decode stages, so none of them is zero
  a_s1_score: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (s1_score != '0))
    else $error("zero score entered the decode stages");
`endif

endmodule

[sim/detection_argmax_box_decode_unit_tb.sv]
// self-checking testbench for the detection argmax and box decode unit
module detection_argmax_box_decode_unit_tb import dabd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS    = 14;
  localparam int BOX_ONE      = 1 << FRAC_BITS;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    score_t score;
    box_t   box_left;
    box_t   box_top;
    box_t   box_right;
    box_t   box_bottom;
    dim_t   region_x;
    dim_t   region_y;
    dim_t   region_w;
    dim_t   region_h;
    id_t    region_id;
    logic   last;
  } slot_t;

  typedef struct packed {
    id_t    id;
    dim_t   x;
    dim_t   y;
    dim_t   w;
    dim_t   h;
    score_t score;
  } detection_t;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic clk;
  logic rst;

  dabd_cfg_if  cfg();
  dabd_slot_if slot();
  dabd_res_if  result();

  detection_argmax_box_decode_unit #(.BOX_FRAC_BITS(FRAC_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .slot   (slot),
    .result (result)
  );

  // register mirror and running-maximum state of the decode model
  score_t thr_reg;
  logic   norm_reg;
  dim_t   width_reg;
  dim_t   height_reg;
  score_t top_score;
  longint top_edge [4];
  bit     run_open;

  detection_t detections_due [$];
  int fail_count   = 0;
  int stall_cycles = 0;

  // stimulus-side view of the settings in force
  bit   gen_norm   = 1'b1;
  int   gen_width  = 1920;
  int   gen_height = 1080;

  // sender and receiver behavior knobs
  bit       tx_gaps       = 1'b1;
  int       tx_burst_left = 0;
  rx_mode_e rx_mode       = RX_RANDOM;
  int       hold_request  = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // clamp corners into a w x h frame, keeping at least one pixel of size
  function automatic void fit_frame(inout longint l, inout longint t, inout longint r,
                                    inout longint b, input longint w, input longint h);
    l = clamp_to(l, 0, w - 2);
    t = clamp_to(t, 0, h - 2);
    r = clamp_to(r, l + 1, w - 1);
    b = clamp_to(b, t + 1, h - 1);
  endfunction

  // fixed-point fraction times crop size, truncated toward zero
  function automatic longint scaled(longint v, longint size);
    return (v * size) / (longint'(1) << FRAC_BITS);
  endfunction

  function automatic void clear_run();
    top_score = '0;
    foreach (top_edge[k]) top_edge[k] = 0;
    run_open = 1'b0;
  endfunction

  // update the running maximum; on a last slot decode the box, 1 when a detection is due
  function automatic bit decode_slot(input slot_t s, output detection_t det);
    longint iw, ih, cl, ct, cr, cb, cw, ch;
    longint l, t, r, b, dx, dy, dw, dh;
    score_t sc;
    if (!run_open || s.score > top_score) begin
      top_score   = s.score;
      top_edge[0] = $signed(s.box_left);
      top_edge[1] = $signed(s.box_top);
      top_edge[2] = $signed(s.box_right);
      top_edge[3] = $signed(s.box_bottom);
    end
    run_open = 1'b1;
    if (!s.last) return 1'b0;

    sc = top_score;
    l  = top_edge[0];
    t  = top_edge[1];
    r  = top_edge[2];
    b  = top_edge[3];
    clear_run();

    iw = width_reg;
    ih = height_reg;
    if (iw < 2 || ih < 2) return 1'b0;

    // crop window in the image
    cl = s.region_x;
    ct = s.region_y;
    cr = cl + longint'(s.region_w);
    cb = ct + longint'(s.region_h);
    fit_frame(cl, ct, cr, cb, iw, ih);
    cw = cr - cl;
    ch = cb - ct;

    if (norm_reg) begin
      l = scaled(l, cw);
      t = scaled(t, ch);
      r = scaled(r, cw);
      b = scaled(b, ch);
    end
    fit_frame(l, t, r, b, cw, ch);
    dx = l;
    dy = t;
    dw = r - l;
    dh = b - t;

    // back into image coordinates
    l = cl + dx;
    t = ct + dy;
    r = l + dw;
    b = t + dh;
    fit_frame(l, t, r, b, iw, ih);

    if (sc <= thr_reg) return 1'b0;
    det.id    = s.region_id;
    det.x     = dim_t'(l);
    det.y     = dim_t'(t);
    det.w     = dim_t'(r - l);
    det.h     = dim_t'(b - t);
    det.score = sc;
    return 1'b1;
  endfunction

  function automatic void check_field(string field, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // observe every handshake: register writes, slot items, result items
  always @(posedge clk) begin
    slot_t      seen;
    detection_t want;
    detection_t got;
    bit         moved;
    if (rst) begin
      thr_reg      = RST_SCORE_THRESHOLD;
      norm_reg     = RST_BOX_NORMALIZED;
      width_reg    = RST_IMAGE_WIDTH;
      height_reg   = RST_IMAGE_HEIGHT;
      clear_run();
      stall_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg.valid && cfg.ready) begin
        moved = 1'b1;
        case (cfg.index)
          REG_SCORE_THRESHOLD: thr_reg    = cfg.data;
          REG_BOX_NORMALIZED:  norm_reg   = cfg.data[0];
          REG_IMAGE_WIDTH:     width_reg  = cfg.data[DIM_BITS-1:0];
          REG_IMAGE_HEIGHT:    height_reg = cfg.data[DIM_BITS-1:0];
          default: ;
        endcase
      end
      if (slot.valid && slot.ready) begin
        moved             = 1'b1;
        seen.score        = slot.score;
        seen.box_left     = slot.box_left;
        seen.box_top      = slot.box_top;
        seen.box_right    = slot.box_right;
        seen.box_bottom   = slot.box_bottom;
        seen.region_x     = slot.region_x;
        seen.region_y     = slot.region_y;
        seen.region_w     = slot.region_w;
        seen.region_h     = slot.region_h;
        seen.region_id    = slot.region_id;
        seen.last         = slot.last;
        if (decode_slot(seen, want)) detections_due = {detections_due, want};
      end
      if (result.valid && result.ready) begin
        moved     = 1'b1;
        got.id    = result.out_id;
        got.x     = result.out_x;
        got.y     = result.out_y;
        got.w     = result.out_w;
        got.h     = result.out_h;
        got.score = result.out_score;
        if (detections_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual id %0d x %0d y %0d",
                   $time, got.id, got.x, got.y);
        end else begin
          want = detections_due.pop_front();
          check_field("out_id", want.id, got.id);
          check_field("out_x", want.x, got.x);
          check_field("out_y", want.y, got.y);
          check_field("out_w", want.w, got.w);
          check_field("out_h", want.h, got.h);
          check_field("out_score", want.score, got.score);
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // result receiver: own stall pattern plus an occasional long hold-off
  initial begin
    int  rx_tick;
    int  hold_left;
    bit  rdy;
    rx_tick   = 0;
    hold_left = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      case (rx_mode)
        RX_FREE:     rdy = 1'b1;
        RX_RANDOM:   rdy = ($urandom_range(0, 99) < 60);
        default:     rdy = ((rx_tick % 9) < 5);
      endcase
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      result.ready <= rdy;
    end
  end

  // offer one slot item, with burst gaps when enabled, and wait for it to be taken
  task automatic send_slot(input slot_t s);
    if (tx_gaps && tx_burst_left == 0) begin
      slot.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      tx_burst_left = $urandom_range(1, 12);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    slot.valid      <= 1'b1;
    slot.score      <= s.score;
    slot.box_left   <= s.box_left;
    slot.box_top    <= s.box_top;
    slot.box_right  <= s.box_right;
    slot.box_bottom <= s.box_bottom;
    slot.region_x   <= s.region_x;
    slot.region_y   <= s.region_y;
    slot.region_w   <= s.region_w;
    slot.region_h   <= s.region_h;
    slot.region_id  <= s.region_id;
    slot.last       <= s.last;
    @(posedge clk);
    while (!slot.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input cfg_data_t val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // wait until every due detection is out, then let the pipeline empty
  task automatic settle();
    while (detections_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input score_t thr, input bit norm, input dim_t w, input dim_t h);
    settle();
    write_reg(REG_SCORE_THRESHOLD, cfg_data_t'(thr));
    write_reg(REG_BOX_NORMALIZED, cfg_data_t'(norm));
    write_reg(REG_IMAGE_WIDTH, cfg_data_t'(w));
    write_reg(REG_IMAGE_HEIGHT, cfg_data_t'(h));
    cfg.valid  <= 1'b0;
    gen_norm   = norm;
    gen_width  = w;
    gen_height = h;
  endtask

  function automatic slot_t mk_slot(score_t sc, int l, int t, int r, int b,
                                    int x, int y, int w, int h, int id, bit last);
    slot_t s;
    s.score      = sc;
    s.box_left   = box_t'(l);
    s.box_top    = box_t'(t);
    s.box_right  = box_t'(r);
    s.box_bottom = box_t'(b);
    s.region_x   = dim_t'(x);
    s.region_y   = dim_t'(y);
    s.region_w   = dim_t'(w);
    s.region_h   = dim_t'(h);
    s.region_id  = id_t'(id);
    s.last       = last;
    return s;
  endfunction

  function automatic score_t pick_score(score_t prev);
    case ($urandom_range(0, 9))
      0:          return prev;
      1, 2, 3, 4: return score_t'($urandom_range(0, 65535));
      default:    return score_t'($urandom_range(40000, 65535));
    endcase
  endfunction

  // box edge: mostly plausible for the mode, sometimes any 18-bit value
  function automatic box_t pick_edge(bit norm, int span);
    int v;
    if ($urandom_range(0, 3) == 0) return box_t'($urandom);
    if (norm) v = int'($urandom_range(0, BOX_ONE + 2000)) - 1000;
    else v = int'($urandom_range(0, span + 100)) - 50;
    return box_t'(v);
  endfunction

  // region: mostly inside the image, some tiny, some anywhere
  function automatic void pick_region(output dim_t x, output dim_t y,
                                      output dim_t w, output dim_t h);
    int iw, ih, px, py;
    iw = (gen_width < 2) ? 64 : gen_width;
    ih = (gen_height < 2) ? 64 : gen_height;
    case ($urandom_range(0, 9))
      0, 1: begin
        x = dim_t'($urandom);
        y = dim_t'($urandom);
        w = dim_t'($urandom);
        h = dim_t'($urandom);
      end
      2: begin
        x = dim_t'($urandom_range(0, iw - 1));
        y = dim_t'($urandom_range(0, ih - 1));
        w = dim_t'($urandom_range(0, 2));
        h = dim_t'($urandom_range(0, 2));
      end
      default: begin
        px = $urandom_range(0, iw - 1);
        py = $urandom_range(0, ih - 1);
        x  = dim_t'(px);
        y  = dim_t'(py);
        w  = dim_t'($urandom_range(1, iw - px));
        h  = dim_t'($urandom_range(1, ih - py));
      end
    endcase
  endfunction

  // runs of slots with random content, a share of them scrambled
  task automatic send_random_runs(input int n_items, input int noise_pct, input int max_len);
    int             sent, len, k;
    slot_t          s;
    logic [191:0]   noise;
    dim_t           rx, ry, rw, rh;
    id_t            rid;
    bit             vary;
    score_t         sc;
    box_t           tmp;
    sent = 0;
    sc   = '0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
      if (len > max_len) len = max_len;
      pick_region(rx, ry, rw, rh);
      rid  = id_t'($urandom);
      vary = ($urandom_range(0, 9) == 0);
      for (k = 0; k < len; k++) begin
        if (vary) pick_region(rx, ry, rw, rh);
        sc           = pick_score(sc);
        s.score      = sc;
        s.box_left   = pick_edge(gen_norm, rw);
        s.box_top    = pick_edge(gen_norm, rh);
        s.box_right  = pick_edge(gen_norm, rw);
        s.box_bottom = pick_edge(gen_norm, rh);
        // keep most boxes well ordered
        if ($signed(s.box_left) > $signed(s.box_right) && $urandom_range(0, 4) != 0) begin
          tmp         = s.box_left;
          s.box_left  = s.box_right;
          s.box_right = tmp;
        end
        if ($signed(s.box_top) > $signed(s.box_bottom) && $urandom_range(0, 4) != 0) begin
          tmp          = s.box_top;
          s.box_top    = s.box_bottom;
          s.box_bottom = tmp;
        end
        s.region_x  = rx;
        s.region_y  = ry;
        s.region_w  = rw;
        s.region_h  = rh;
        s.region_id = rid;
        s.last      = (k == len - 1);
        if ($urandom_range(0, 99) < noise_pct) begin
          noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
          s     = noise[$bits(slot_t)-1:0];
        end
        send_slot(s);
      end
      sent += len;
    end
    slot.valid <= 1'b0;
  endtask

  // hand-picked slots under the reset settings
  task automatic test_directed_decode();
    slot_t plan [$];
    tx_gaps = 1'b0;
    rx_mode = RX_RANDOM;
    // full box in a crop, extreme id
    plan = {plan, mk_slot(16'hFFFF, 0, 0, BOX_ONE, BOX_ONE, 100, 50, 400, 300,
                          32'h7FFF_FFFF, 1'b1)};
    // tie of top scores: earlier slot keeps its box
    plan = {plan, mk_slot(16'd50000, 1000, 1000, 4000, 4000, 10, 20, 800, 600, 0, 1'b0)};
    plan = {plan, mk_slot(16'd60000, 2000, 2000, 9000, 9000, 10, 20, 800, 600, 0, 1'b0)};
    plan = {plan, mk_slot(16'd60000, 5000, 5000, 6000, 6000, 10, 20, 800, 600,
                          int'(32'h8000_0000), 1'b1)};
    // score equal to threshold gives nothing, one above gives a detection
    plan = {plan, mk_slot(RST_SCORE_THRESHOLD, 100, 100, 9000, 9000, 0, 0, 1920, 1080,
                          7, 1'b1)};
    plan = {plan, mk_slot(score_t'(RST_SCORE_THRESHOLD + 16'd1), 100, 100, 9000, 9000,
                          0, 0, 1920, 1080, 8, 1'b1)};
    // state starts over after a last slot
    plan = {plan, mk_slot(16'd65000, 3000, 3000, 12000, 12000, 200, 200, 500, 500,
                          9, 1'b1)};
    plan = {plan, mk_slot(16'd46000, 8000, 100, 16000, 7000, 200, 200, 500, 500,
                          10, 1'b1)};
    // region changing inside a run: the last slot's region counts
    plan = {plan, mk_slot(16'd60000, 4000, 4000, 12000, 12000, 0, 0, 100, 100, 11, 1'b0)};
    plan = {plan, mk_slot(16'd50000, 0, 0, 100, 100, 1000, 500, 700, 400, 12, 1'b1)};
    // region far outside the image
    plan = {plan, mk_slot(16'd65535, 2000, 2000, 10000, 10000, 8191, 8191, 8191, 8191,
                          13, 1'b1)};
    // one-pixel crop with a box left of and above it
    plan = {plan, mk_slot(16'd65535, -5000, -5000, 300, 300, 500, 600, 1, 1, 14, 1'b1)};
    // box edges at the field extremes, both orders
    plan = {plan, mk_slot(16'd65535, -131072, -131072, 131071, 131071, 30, 40, 1000, 900,
                          15, 1'b1)};
    plan = {plan, mk_slot(16'd65535, 131071, 131071, -131072, -131072, 30, 40, 1000, 900,
                          16, 1'b1)};
    // zero score still claims the first slot, no detection
    plan = {plan, mk_slot(16'd0, 100, 100, 200, 200, 5, 5, 50, 50, 17, 1'b1)};
    // empty region in the corner
    plan = {plan, mk_slot(16'd65535, 0, 0, BOX_ONE, BOX_ONE, 0, 0, 0, 0, -1, 1'b1)};
    // region hugging the far corner
    plan = {plan, mk_slot(16'd65535, 0, 0, BOX_ONE, BOX_ONE, 1919, 1079, 8191, 8191,
                          18, 1'b1)};
    foreach (plan[i]) send_slot(plan[i]);
    slot.valid <= 1'b0;
  endtask

  // extremes of every register, including images too small to decode into
  task automatic test_config_extremes();
    rx_mode = RX_PERIODIC;
    tx_gaps = 1'b1;
    set_config(16'd0, 1'b0, 13'd1920, 13'd1080);
    send_random_runs(40, 10, 24);
    set_config(16'hFFFF, 1'b1, 13'd8191, 13'd8191);
    send_random_runs(40, 10, 24);
    rx_mode = RX_FREE;
    set_config(16'd0, 1'b1, 13'd2, 13'd2);
    send_random_runs(40, 10, 24);
    set_config(16'd100, 1'b0, 13'd8191, 13'd2);
    send_random_runs(40, 10, 24);
    tx_gaps = 1'b0;
    set_config(16'd30000, 1'b1, 13'd0, 13'd1080);
    send_random_runs(30, 10, 24);
    set_config(16'd30000, 1'b0, 13'd640, 13'd1);
    send_random_runs(30, 10, 24);
    rx_mode = RX_RANDOM;
    set_config(16'd1, 1'b1, 13'd2, 13'd8191);
    send_random_runs(40, 10, 24);
  endtask

  // bulk random runs under a few settings and both idling styles
  task automatic test_random_traffic();
    set_config(RST_SCORE_THRESHOLD, 1'b1, 13'd1920, 13'd1080);
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b1;
    send_random_runs(250, 15, 24);
    tx_gaps = 1'b0;
    rx_mode = RX_FREE;
    send_random_runs(200, 15, 24);

    set_config(16'd20000, 1'b0, 13'd1280, 13'd720);
    rx_mode = RX_PERIODIC;
    tx_gaps = 1'b1;
    send_random_runs(250, 15, 24);
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b0;
    send_random_runs(200, 15, 24);

    set_config(16'd8000, 1'b1, dim_t'($urandom_range(2, 8191)),
               dim_t'($urandom_range(2, 8191)));
    rx_mode = RX_FREE;
    tx_gaps = 1'b1;
    send_random_runs(250, 15, 24);
    rx_mode = RX_PERIODIC;
    tx_gaps = 1'b0;
    send_random_runs(200, 15, 24);
  endtask

  // receiver holds off while one-slot regions keep coming, so the block backs up
  task automatic test_backpressure();
    set_config(16'd0, 1'b1, 13'd1920, 13'd1080);
    rx_mode      = RX_FREE;
    tx_gaps      = 1'b0;
    hold_request = LONG_HOLD;
    send_random_runs(150, 0, 1);
  endtask

  initial begin
    rst             <= 1'b1;
    cfg.valid       <= 1'b0;
    cfg.index       <= REG_SCORE_THRESHOLD;
    cfg.data        <= '0;
    slot.valid      <= 1'b0;
    slot.score      <= '0;
    slot.box_left   <= '0;
    slot.box_top    <= '0;
    slot.box_right  <= '0;
    slot.box_bottom <= '0;
    slot.region_x   <= '0;
    slot.region_y   <= '0;
    slot.region_w   <= '0;
    slot.region_h   <= '0;
    slot.region_id  <= '0;
    slot.last       <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_decode();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    settle();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dabd_pkg.sv
rtl/dabd_if.sv
rtl/detection_argmax_box_decode_unit.sv
sim/detection_argmax_box_decode_unit_tb.sv
